// ----- sv/bdeq_pkg.sv -----
`timescale 1ns / 1ps

package bdeq_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;
    localparam int OCC_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

// ----- sv/bdeq_ctrl.sv -----
`timescale 1ns / 1ps

module bdeq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output bdeq_pkg::dp_cmd_t cmd
);
    import bdeq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign busy   = (state_reg == S_EXEC);
    assign done   = (state_reg == S_RESP);
    assign accept = start && !busy;

    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // take the next beat while this result is on the ports
                state_next = accept ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/bdeq_dp.sv -----
`timescale 1ns / 1ps

module bdeq_dp
#(
    parameter int DEPTH = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bdeq_pkg::dp_cmd_t               cmd,
    input  logic [bdeq_pkg::ACTION_W-1:0]   action,
    input  logic [bdeq_pkg::WORD_W-1:0]     push_word,
    output logic [bdeq_pkg::STATUS_W-1:0]   status,
    output logic [bdeq_pkg::WORD_W-1:0]     popped_word,
    output logic [bdeq_pkg::OCC_W-1:0]      occupancy
);
    import bdeq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [WORD_W-1:0]   mem [DEPTH];

    logic [ACTION_W-1:0] act_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [PW-1:0]       front_reg;
    logic [PW-1:0]       front_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                rev_reg;
    logic                rev_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                pop_ok_reg;
    logic                pop_ok_next;
    logic [WORD_W-1:0]   rd_data_reg;

    logic                full;
    logic                empty;
    logic                push_head;
    logic                pop_head;
    logic [PW-1:0]       front_dec;
    logic [PW-1:0]       front_inc;
    logic [CW-1:0]       tail_off;
    logic [SW-1:0]       tail_sum;
    logic [PW-1:0]       tail_slot;
    logic [PW-1:0]       addr;
    logic                wr_en;
    logic                rd_en;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_head = (act_reg == ACT_PUSH_FRONT) != rev_reg;
    assign pop_head  = (act_reg == ACT_POP_FRONT) != rev_reg;

    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // push at the tail uses slot front+count, pop at the tail front+count-1
    assign tail_off  = (act_reg == ACT_POP_BACK || act_reg == ACT_POP_FRONT)
                       ? count_reg - 1'b1 : count_reg;
    assign tail_sum  = SW'(front_reg) + SW'(tail_off);
    assign tail_slot = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH))
                                                : PW'(tail_sum);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = STAT_OK;
        pop_ok_next = 1'b0;
        addr        = tail_slot;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (act_reg)
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
            begin
                if (full)
                    status_next = STAT_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (push_head)
                    begin
                        addr       = front_dec;
                        front_next = front_dec;
                    end
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT:
            begin
                if (empty)
                    status_next = STAT_EMPTY;
                else
                begin
                    rd_en       = 1'b1;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (pop_head)
                    begin
                        addr       = front_reg;
                        front_next = front_inc;
                    end
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
                front_next = '0;
                rev_next   = 1'b0;
            end
            ACT_REVERSE:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            status_reg <= STAT_OK;
            pop_ok_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            word_reg <= push_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            mem[addr] <= word_reg;
        if (cmd.exec && rd_en)
            rd_data_reg <= mem[addr];
    end

    assign status      = status_reg;
    assign popped_word = pop_ok_reg ? rd_data_reg : '0;
    assign occupancy   = OCC_W'(count_reg);

endmodule

// ----- sv/bounded_double_ended_queue_top.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH 64-bit words, kept bit for bit.
// Request channel: action and push_word are taken at a rising edge with start
// high and busy low. Actions: push back/front, pop back/front, clear, reverse.
// Result channel: done is high for exactly one cycle while status, popped_word
// and occupancy show the result; the receiver cannot stall it.
// Sequencing: the request beat registers action and push_word; the execute
// state updates the ring pointers and performs the word store write or read;
// the response state presents the registered result. busy is high during the
// execute state only, so a new request may be taken while a result is on the
// ports. The controller holds busy through the execute state.
// Reverse toggles a direction flag and goes through the same states as any
// other request; push on a full queue or pop on an empty one leaves the queue unchanged.
// Reset: the queue is empty, in natural order, with no result pending. The
// word store holds no reset value; a pop only reads words that were pushed.

module bounded_double_ended_queue_top
#(
    parameter int DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bdeq_pkg::ACTION_W-1:0] action,
    input  logic [bdeq_pkg::WORD_W-1:0]   push_word,
    output logic                          done,
    output logic [bdeq_pkg::STATUS_W-1:0] status,
    output logic [bdeq_pkg::WORD_W-1:0]   popped_word,
    output logic [bdeq_pkg::OCC_W-1:0]    occupancy
);
    import bdeq_pkg::*;

    dp_cmd_t cmd;

    bdeq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bdeq_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .push_word   (push_word),
        .status      (status),
        .popped_word (popped_word),
        .occupancy   (occupancy)
    );

endmodule

// ----- sv/bdeq_chk.sv -----
`timescale 1ns / 1ps

module bdeq_chk
#(
    parameter int DEPTH = 64
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [bdeq_pkg::STATUS_W-1:0] status,
    input logic [bdeq_pkg::WORD_W-1:0]   popped_word,
    input logic [bdeq_pkg::OCC_W-1:0]    occupancy
);
    import bdeq_pkg::*;

    // an accepted beat always occupies the engine for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // every busy cycle is followed by exactly one result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("missing result after busy cycle");

    // a failed pop reports an empty queue and no word
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_EMPTY |-> popped_word == '0 && occupancy == '0)
        else $error("empty status with data or nonzero occupancy");

    // a refused push only happens with the queue at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_FULL |-> occupancy == OCC_W'(DEPTH)
            && popped_word == '0)
        else $error("full status below capacity");

endmodule

bind bounded_double_ended_queue_top bdeq_chk
#(
    .DEPTH (DEPTH)
)
u_bdeq_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .popped_word (popped_word),
    .occupancy   (occupancy)
);
